/* hw/rtl/assert_macros.svh */
// Concurrent assertion helpers for the shaper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define JLTS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define JLTS_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define JLTS_ASSERT(lbl, clk, rstn, prop)
`define JLTS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

/* hw/rtl/jlts_pkg.sv */
`timescale 1ns / 1ps
package jlts_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int ALPHA_BITS     = 16;
    localparam int BND_W          = 26;
    localparam int NW             = 36;

    localparam logic [16:0] SF_Q16   = 17'd64225;
    localparam logic [9:0]  CENT_Q16 = 10'd655;

    localparam logic [2:0] ZONE_SAFE     = 3'd0;
    localparam logic [2:0] ZONE_MIN_SOFT = 3'd1;
    localparam logic [2:0] ZONE_MIN_HARD = 3'd2;
    localparam logic [2:0] ZONE_MAX_SOFT = 3'd3;
    localparam logic [2:0] ZONE_MAX_HARD = 3'd4;

    localparam logic [2:0] OP_PASS       = 3'd0;
    localparam logic [2:0] OP_ANGLE_SOFT = 3'd1;
    localparam logic [2:0] OP_ANGLE_HARD = 3'd2;
    localparam logic [2:0] OP_VEL_SOFT   = 3'd3;
    localparam logic [2:0] OP_VEL_HARD   = 3'd4;

    localparam logic [2:0] CFG_ANGLE_MIN = 3'd0;
    localparam logic [2:0] CFG_ANGLE_MAX = 3'd1;
    localparam logic [2:0] CFG_ANGLE_TOL = 3'd2;
    localparam logic [2:0] CFG_VEL_LIM   = 3'd3;
    localparam logic [2:0] CFG_VEL_TOL   = 3'd4;
    localparam logic [2:0] CFG_TORQUE    = 3'd5;
    localparam logic [2:0] CFG_DAMPING   = 3'd6;

    typedef struct packed {
        logic signed [31:0] torque_in;
        logic signed [31:0] joint_angle;
        logic signed [31:0] joint_velocity;
    } in_t;

    typedef struct packed {
        logic signed [31:0] torque_out;
        logic [2:0]         position_zone;
        logic [2:0]         velocity_zone;
        logic               limited;
    } out_t;

    typedef struct packed {
        logic signed [18:0] angle_min_limit;
        logic [18:0]        angle_max_limit;
        logic [16:0]        angle_tolerance;
        logic [18:0]        velocity_limit;
        logic [16:0]        velocity_tolerance;
        logic [23:0]        torque_limit;
        logic [24:0]        damping_gain;
    } cfg_t;

    // classified word handed from the front to the back
    typedef struct packed {
        logic [2:0]           op;
        logic                 neg;
        logic [2:0]           pz;
        logic [2:0]           vz;
        logic signed [31:0]   tau;
        logic signed [31:0]   dq;
        logic signed [NW-1:0] n;
        logic signed [NW-1:0] d;
        logic [24:0]          kv;
        logic [23:0]          tl;
    } work_t;

endpackage

/* hw/rtl/jlts_front.sv */
`timescale 1ns / 1ps
module jlts_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  jlts_pkg::cfg_t cfg,
    input  logic           s_valid,
    output logic           s_ready,
    input  jlts_pkg::in_t  s_data,
    output logic           q_valid,
    input  logic           q_ready,
    output jlts_pkg::work_t q_data
);
    import jlts_pkg::*;

    typedef struct packed {
        logic signed [BND_W-1:0] soft_min;
        logic signed [BND_W-1:0] hard_min;
        logic signed [BND_W-1:0] soft_max;
        logic signed [BND_W-1:0] hard_max;
        logic signed [BND_W-1:0] vsoft_min;
        logic signed [BND_W-1:0] vhard_min;
        logic signed [BND_W-1:0] vsoft_max;
        logic signed [BND_W-1:0] vhard_max;
        logic signed [BND_W-1:0] qmin;
        logic signed [BND_W-1:0] qmax;
        logic signed [BND_W-1:0] vmax;
    } bnd_t;

    localparam logic signed [BND_W-1:0] K6  = BND_W'(6);
    localparam logic signed [BND_W-1:0] K8  = BND_W'(8);
    localparam logic signed [BND_W-1:0] K9  = BND_W'(9);
    localparam logic signed [BND_W-1:0] K10 = BND_W'(10);

    logic               adv;
    logic               f1_vld_reg;
    logic               f2_vld_reg;
    in_t                in_reg;
    bnd_t               bnd_reg;
    bnd_t               bnd_next;
    logic [24:0]        kv_reg;
    logic [23:0]        tl_reg;
    work_t              work_reg;
    work_t              work_next;

    logic signed [36:0]      pmin_p;
    logic signed [36:0]      pmax_p;
    logic signed [36:0]      vl_p;
    logic signed [BND_W-1:0] pmin;
    logic signed [BND_W-1:0] pmax;
    logic signed [BND_W-1:0] vl;
    logic signed [BND_W-1:0] at_w;
    logic signed [BND_W-1:0] vt_w;

    logic signed [NW-1:0] q_w;
    logic signed [NW-1:0] dq_w;
    logic signed [NW-1:0] v_sel;
    logic signed [NW-1:0] a_sel;
    logic signed [NW-1:0] b_sel;
    logic signed [NW-1:0] n_raw;
    logic signed [NW-1:0] d_raw;
    logic [2:0]           pz;
    logic [2:0]           vz;

    // derived limits follow the registers every cycle
    always_comb begin
        pmin_p = 37'(cfg.angle_min_limit) * $signed({20'd0, SF_Q16});
        pmax_p = $signed(37'({1'b0, cfg.angle_max_limit}) * 37'({1'b0, SF_Q16}));
        vl_p   = $signed(37'({1'b0, cfg.velocity_limit}) * 37'({1'b0, SF_Q16}));
        pmin   = BND_W'(pmin_p >>> 16);
        pmax   = BND_W'(pmax_p >>> 16);
        vl     = BND_W'(vl_p >>> 16);
        at_w   = $signed(BND_W'(cfg.angle_tolerance));
        vt_w   = $signed(BND_W'(cfg.velocity_tolerance));
        bnd_next.soft_min  = pmin + at_w * K9;
        bnd_next.hard_min  = pmin + at_w * K6;
        bnd_next.soft_max  = pmax - at_w * K9;
        bnd_next.hard_max  = pmax - at_w * K6;
        bnd_next.vsoft_min = vt_w * K10 - vl;
        bnd_next.vhard_min = vt_w * K8 - vl;
        bnd_next.vsoft_max = vl - vt_w * K10;
        bnd_next.vhard_max = vl - vt_w * K8;
        bnd_next.qmin      = BND_W'(cfg.angle_min_limit);
        bnd_next.qmax      = $signed(BND_W'(cfg.angle_max_limit));
        bnd_next.vmax      = $signed(BND_W'(cfg.velocity_limit));
    end

    // classify and pick the blend end points
    always_comb begin
        q_w  = NW'(in_reg.joint_angle);
        dq_w = NW'(in_reg.joint_velocity);
        pz   = ZONE_SAFE;
        vz   = ZONE_SAFE;
        if (q_w > NW'(bnd_reg.soft_min) && q_w < NW'(bnd_reg.soft_max)) begin
            pz = ZONE_SAFE;
        end else if (q_w < NW'(bnd_reg.hard_min)) begin
            pz = ZONE_MIN_HARD;
        end else if (q_w < NW'(bnd_reg.soft_min)) begin
            pz = ZONE_MIN_SOFT;
        end else if (q_w > NW'(bnd_reg.hard_max)) begin
            pz = ZONE_MAX_HARD;
        end else if (q_w > NW'(bnd_reg.soft_max)) begin
            pz = ZONE_MAX_SOFT;
        end
        if (pz == ZONE_SAFE) begin
            if (dq_w > NW'(bnd_reg.vsoft_min) && dq_w < NW'(bnd_reg.vsoft_max)) begin
                vz = ZONE_SAFE;
            end else if (dq_w > NW'(bnd_reg.vhard_max)) begin
                vz = ZONE_MAX_HARD;
            end else if (dq_w > NW'(bnd_reg.vsoft_max)) begin
                vz = ZONE_MAX_SOFT;
            end else if (dq_w < NW'(bnd_reg.vhard_min)) begin
                vz = ZONE_MIN_HARD;
            end else if (dq_w < NW'(bnd_reg.vsoft_min)) begin
                vz = ZONE_MIN_SOFT;
            end
        end

        v_sel = q_w;
        a_sel = NW'(bnd_reg.soft_min);
        b_sel = NW'(bnd_reg.hard_min);
        work_next.op  = OP_PASS;
        work_next.neg = 1'b0;
        unique case (pz)
            ZONE_MIN_SOFT: begin
                work_next.op = OP_ANGLE_SOFT;
            end
            ZONE_MAX_SOFT: begin
                work_next.op = OP_ANGLE_SOFT;
                a_sel = NW'(bnd_reg.soft_max);
                b_sel = NW'(bnd_reg.hard_max);
            end
            ZONE_MIN_HARD: begin
                work_next.op = OP_ANGLE_HARD;
                a_sel = NW'(bnd_reg.hard_min);
                b_sel = NW'(bnd_reg.qmin);
            end
            ZONE_MAX_HARD: begin
                work_next.op  = OP_ANGLE_HARD;
                work_next.neg = 1'b1;
                a_sel = NW'(bnd_reg.hard_max);
                b_sel = NW'(bnd_reg.qmax);
            end
            default: begin
                v_sel = dq_w;
                unique case (vz)
                    ZONE_MIN_SOFT: begin
                        work_next.op = OP_VEL_SOFT;
                        a_sel = NW'(bnd_reg.vsoft_min);
                        b_sel = NW'(bnd_reg.vhard_min);
                    end
                    ZONE_MAX_SOFT: begin
                        work_next.op = OP_VEL_SOFT;
                        a_sel = NW'(bnd_reg.vsoft_max);
                        b_sel = NW'(bnd_reg.vhard_max);
                    end
                    ZONE_MIN_HARD: begin
                        work_next.op = OP_VEL_HARD;
                        a_sel = NW'(bnd_reg.vhard_min);
                        b_sel = -NW'(bnd_reg.vmax);
                    end
                    ZONE_MAX_HARD: begin
                        work_next.op  = OP_VEL_HARD;
                        work_next.neg = 1'b1;
                        a_sel = NW'(bnd_reg.vhard_max);
                        b_sel = NW'(bnd_reg.vmax);
                    end
                    default: begin
                        work_next.op = OP_PASS;
                    end
                endcase
            end
        endcase

        n_raw = v_sel - a_sel;
        d_raw = b_sel - a_sel;
        // fold a falling ramp onto a rising one
        work_next.n   = d_raw[NW-1] ? -n_raw : n_raw;
        work_next.d   = d_raw[NW-1] ? -d_raw : d_raw;
        work_next.pz  = pz;
        work_next.vz  = vz;
        work_next.tau = in_reg.torque_in;
        work_next.dq  = in_reg.joint_velocity;
        work_next.kv  = kv_reg;
        work_next.tl  = tl_reg;
    end

    assign adv     = !f2_vld_reg || q_ready;
    assign s_ready = adv;
    assign q_valid = f2_vld_reg;
    assign q_data  = work_reg;

    always_ff @(posedge aclk) begin
        bnd_reg <= bnd_next;
        kv_reg  <= cfg.damping_gain;
        tl_reg  <= cfg.torque_limit;
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end else if (adv) begin
            f1_vld_reg <= s_valid;
            f2_vld_reg <= f1_vld_reg;
        end
        if (adv) begin
            in_reg   <= s_data;
            work_reg <= work_next;
        end
    end

endmodule

/* hw/rtl/jlts_fifo.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module jlts_fifo #(
    parameter int DEPTH = jlts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  jlts_pkg::work_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output jlts_pkg::work_t rd_data
);
    import jlts_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_t            mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = count_reg != CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `JLTS_ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > CNT_W'(DEPTH))
    `JLTS_ASSERT(a_count_inc, aclk, aresetn, (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
    `JLTS_ASSERT(a_count_dec, aclk, aresetn, (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)

endmodule

/* hw/rtl/jlts_back.sv */
`timescale 1ns / 1ps
module jlts_back #(
    parameter int FRAC_BITS = jlts_pkg::FRAC_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  jlts_pkg::work_t q_data,
    output logic            m_valid,
    input  logic            m_ready,
    output jlts_pkg::out_t  m_data
);
    import jlts_pkg::*;

    localparam int NS = ALPHA_BITS + 1;
    localparam int AL = ALPHA_BITS + 1;
    localparam int RW = 60;
    localparam logic [AL-1:0] ALPHA_ONE = AL'(1) << ALPHA_BITS;

    typedef struct packed {
        logic [2:0]         op;
        logic               neg;
        logic [2:0]         pz;
        logic [2:0]         vz;
        logic signed [31:0] tau;
        logic signed [31:0] dq;
        logic [24:0]        kv;
        logic [23:0]        tl;
        logic               one;
        logic               zero;
    } meta_t;

    logic                 en;
    logic [NS-1:0]        vld_reg;
    meta_t                meta_reg [NS];
    logic [NW-1:0]        rem_reg  [NS];
    logic [NW-1:0]        den_reg  [NS];
    logic [ALPHA_BITS-1:0] quo_reg [NS];

    logic [NW:0]          trial    [NS];
    logic                 take     [NS];

    // multiply stages
    logic                 m1_vld_reg, m2_vld_reg, m3_vld_reg, out_vld_reg;
    meta_t                m1_meta_reg, m2_meta_reg, m3_meta_reg;
    logic [AL-1:0]        a2_reg;
    logic [24:0]          t1_reg;
    logic signed [33:0]   fade_reg;
    logic signed [57:0]   kvdq_reg;
    logic signed [33:0]   hdiff_reg;
    logic [AL-1:0]        a4_reg;
    logic signed [57:0]   damp_s_reg;
    logic signed [35:0]   hterm_reg;
    logic signed [57:0]   damp_k_reg;
    logic signed [33:0]   fade2_reg;
    logic [40:0]          a4tl_reg;
    logic signed [RW-1:0] res_reg;
    out_t                 out_reg;

    logic [AL-1:0]              alpha;
    logic [AL-1:0]              inv_alpha;
    logic [2*AL-1:0]            aa;
    logic [AL+24:0]             ak;
    logic signed [AL+32:0]      fade_p;
    logic signed [33:0]         hold;
    logic [2*AL-1:0]            aa2;
    logic signed [57:0]         damp_s_p;
    logic signed [AL+34:0]      hterm_p;
    logic signed [RW-1:0]       res3;
    logic [50:0]                vh_p;
    logic signed [RW-1:0]       vh;
    logic signed [RW-1:0]       res4;
    logic signed [31:0]         sat;

    assign en      = !out_vld_reg || m_ready;
    assign q_ready = en;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // one quotient bit per stage
    always_comb begin
        for (int i = 0; i < NS; i++) begin
            trial[i] = {rem_reg[i], 1'b0};
            take[i]  = trial[i] >= {1'b0, den_reg[i]};
        end
    end

    always_comb begin
        alpha = meta_reg[NS-1].one  ? ALPHA_ONE :
                meta_reg[NS-1].zero ? '0 : {1'b0, quo_reg[NS-1]};
        inv_alpha = ALPHA_ONE - alpha;
        aa     = alpha * alpha;
        ak     = alpha * (AL + 25)'(meta_reg[NS-1].kv);
        fade_p = $signed({1'b0, inv_alpha}) * meta_reg[NS-1].tau;
        hold   = $signed(34'(meta_reg[NS-1].tl));
        if (meta_reg[NS-1].neg) begin
            hold = -hold;
        end

        aa2      = a2_reg * a2_reg;
        damp_s_p = $signed({1'b0, t1_reg}) * m1_meta_reg.dq;
        hterm_p  = $signed({1'b0, a2_reg}) * hdiff_reg;

        case (m2_meta_reg.op)
            OP_ANGLE_SOFT: res3 = RW'(m2_meta_reg.tau) - RW'(damp_s_reg);
            OP_ANGLE_HARD: res3 = RW'(m2_meta_reg.tau) + RW'(hterm_reg) - RW'(damp_k_reg);
            OP_VEL_SOFT:   res3 = RW'(fade2_reg);
            default:       res3 = RW'(m2_meta_reg.tau);
        endcase

        vh_p = a4tl_reg * 51'(CENT_Q16);
        vh   = $signed(RW'(vh_p[50:32]));
        res4 = res_reg;
        if (m3_meta_reg.op == OP_VEL_HARD) begin
            res4 = m3_meta_reg.neg ? -vh : vh;
        end
        if (res4 > RW'(32'sh7fffffff)) begin
            sat = 32'sh7fffffff;
        end else if (res4 < -RW'(33'sh080000000)) begin
            sat = 32'sh80000000;
        end else begin
            sat = 32'(res4);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            m3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[NS-2:0], q_valid};
            m1_vld_reg  <= vld_reg[NS-1];
            m2_vld_reg  <= m1_vld_reg;
            m3_vld_reg  <= m2_vld_reg;
            out_vld_reg <= m3_vld_reg;
        end
        if (en) begin
            meta_reg[0].op   <= q_data.op;
            meta_reg[0].neg  <= q_data.neg;
            meta_reg[0].pz   <= q_data.pz;
            meta_reg[0].vz   <= q_data.vz;
            meta_reg[0].tau  <= q_data.tau;
            meta_reg[0].dq   <= q_data.dq;
            meta_reg[0].kv   <= q_data.kv;
            meta_reg[0].tl   <= q_data.tl;
            meta_reg[0].one  <= (q_data.d == '0) || (q_data.n >= q_data.d);
            meta_reg[0].zero <= q_data.n[NW-1] || (q_data.n == '0);
            rem_reg[0]       <= q_data.n;
            den_reg[0]       <= q_data.d;
            quo_reg[0]       <= '0;
            for (int i = 1; i < NS; i++) begin
                meta_reg[i] <= meta_reg[i-1];
                den_reg[i]  <= den_reg[i-1];
                rem_reg[i]  <= take[i-1] ? NW'(trial[i-1] - {1'b0, den_reg[i-1]})
                                         : NW'(trial[i-1]);
                quo_reg[i]  <= {quo_reg[i-1][ALPHA_BITS-2:0], take[i-1]};
            end

            m1_meta_reg <= meta_reg[NS-1];
            a2_reg      <= aa[ALPHA_BITS +: AL];
            t1_reg      <= ak[ALPHA_BITS +: 25];
            fade_reg    <= fade_p[ALPHA_BITS +: 34];
            kvdq_reg    <= $signed({1'b0, meta_reg[NS-1].kv}) * meta_reg[NS-1].dq;
            hdiff_reg   <= hold - 34'(meta_reg[NS-1].tau);

            m2_meta_reg <= m1_meta_reg;
            a4_reg      <= aa2[ALPHA_BITS +: AL];
            damp_s_reg  <= damp_s_p >>> FRAC_BITS;
            hterm_reg   <= hterm_p[ALPHA_BITS +: 36];
            damp_k_reg  <= kvdq_reg >>> FRAC_BITS;
            fade2_reg   <= fade_reg;

            m3_meta_reg <= m2_meta_reg;
            a4tl_reg    <= 41'(a4_reg) * 41'(m2_meta_reg.tl);
            res_reg     <= res3;

            out_reg.torque_out    <= sat;
            out_reg.position_zone <= m3_meta_reg.pz;
            out_reg.velocity_zone <= m3_meta_reg.vz;
            out_reg.limited       <= (m3_meta_reg.pz != ZONE_SAFE) ||
                                     (m3_meta_reg.vz != ZONE_SAFE);
        end
    end

endmodule

/* hw/rtl/joint_limit_torque_shaper_core.sv */
`timescale 1ns / 1ps
// Joint limit torque shaper: one joint sample in, one shaped torque word out.
// Input channel s_valid/s_ready/s_data carries torque, angle and velocity;
// result channel m_valid/m_ready/m_data carries the shaped torque, the angle
// and velocity zones and the limited flag. Both are valid/ready handshakes.
// Limits are written through cfg_valid/cfg_ready/cfg_index/cfg_data, always
// ready; write them only while no word is in flight, unknown indexes are
// dropped.
// Throughput is one word per clock while the receiver is ready. The path from
// input accept to result valid runs through two front stages (limit compare
// and ramp set-up), the queue, the ramp divider stages (one quotient bit each),
// then three multiply stages and the output register.
// A short queue sits between the classifying front end and the arithmetic
// back end. When the receiver stalls, the back end holds as a whole while the
// front keeps taking words until the queue fills.
// Reset (aresetn low, synchronous) empties every stage and loads the default
// limits; no clearing pass is needed.
module joint_limit_torque_shaper_core #(
    parameter int FRAC_BITS   = jlts_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = jlts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  jlts_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output jlts_pkg::out_t m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import jlts_pkg::*;

    cfg_t  cfg_reg;
    logic  fq_valid;
    logic  fq_ready;
    work_t fq_data;
    logic  bq_valid;
    logic  bq_ready;
    work_t bq_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.angle_min_limit    <= -19'sd189878;
            cfg_reg.angle_max_limit    <= 19'd189878;
            cfg_reg.angle_tolerance    <= 17'd655;
            cfg_reg.velocity_limit     <= 19'd142541;
            cfg_reg.velocity_tolerance <= 17'd655;
            cfg_reg.torque_limit       <= 24'd5701632;
            cfg_reg.damping_gain       <= 25'd6553600;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ANGLE_MIN: cfg_reg.angle_min_limit    <= $signed(cfg_data[18:0]);
                CFG_ANGLE_MAX: cfg_reg.angle_max_limit    <= cfg_data[18:0];
                CFG_ANGLE_TOL: cfg_reg.angle_tolerance    <= cfg_data[16:0];
                CFG_VEL_LIM:   cfg_reg.velocity_limit     <= cfg_data[18:0];
                CFG_VEL_TOL:   cfg_reg.velocity_tolerance <= cfg_data[16:0];
                CFG_TORQUE:    cfg_reg.torque_limit       <= cfg_data[23:0];
                CFG_DAMPING:   cfg_reg.damping_gain       <= cfg_data[24:0];
                default: begin
                end
            endcase
        end
    end

    jlts_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_data  (fq_data)
    );

    jlts_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (bq_valid),
        .rd_ready (bq_ready),
        .rd_data  (bq_data)
    );

    jlts_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (bq_valid),
        .q_ready (bq_ready),
        .q_data  (bq_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* test/joint_limit_torque_shaper_core_tb.sv */
`timescale 1ns / 1ps
module joint_limit_torque_shaper_core_tb;
    import jlts_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    joint_limit_torque_shaper_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // limits as the block holds them
    longint qmin, qmax, atol, vmax, vtol, tlim, kvel;
    out_t   shaped_q[$];
    int     errors = 0;
    int     burst_left = 0;

    function automatic longint ramp_frac(longint v, longint a, longint b);
        longint n, d;
        n = v - a;
        d = b - a;
        if (d == 0) return 65536;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        if (n <= 0) return 0;
        if (n >= d) return 65536;
        return (n * 65536) / d;
    endfunction

    function automatic out_t shape_torque(in_t w);
        longint tau, q, dq, pmin, pmax, vl, smin, hmin, smax, hmax;
        longint vsmin, vhmin, vsmax, vhmax, res, alpha, a2, a4, hold;
        logic [2:0] pz, vz;
        out_t r;
        tau = w.torque_in;
        q = w.joint_angle;
        dq = w.joint_velocity;
        pmin = (qmin * 64225) >>> 16;
        pmax = (qmax * 64225) >>> 16;
        vl = (vmax * 64225) >>> 16;
        smin = pmin + 9 * atol;
        hmin = pmin + 6 * atol;
        smax = pmax - 9 * atol;
        hmax = pmax - 6 * atol;
        vsmin = -vl + 10 * vtol;
        vhmin = -vl + 8 * vtol;
        vsmax = vl - 10 * vtol;
        vhmax = vl - 8 * vtol;
        pz = ZONE_SAFE;
        vz = ZONE_SAFE;
        res = tau;
        if (q > smin && q < smax) pz = ZONE_SAFE;
        else if (q < hmin) pz = ZONE_MIN_HARD;
        else if (q < smin) pz = ZONE_MIN_SOFT;
        else if (q > hmax) pz = ZONE_MAX_HARD;
        else if (q > smax) pz = ZONE_MAX_SOFT;
        if (pz == ZONE_SAFE) begin
            if (dq > vsmin && dq < vsmax) vz = ZONE_SAFE;
            else if (dq > vhmax) vz = ZONE_MAX_HARD;
            else if (dq > vsmax) vz = ZONE_MAX_SOFT;
            else if (dq < vhmin) vz = ZONE_MIN_HARD;
            else if (dq < vsmin) vz = ZONE_MIN_SOFT;
        end
        if (pz == ZONE_MIN_SOFT || pz == ZONE_MAX_SOFT) begin
            alpha = (pz == ZONE_MIN_SOFT) ? ramp_frac(q, smin, hmin) : ramp_frac(q, smax, hmax);
            res = tau - ((((alpha * kvel) >>> 16) * dq) >>> 16);
        end else if (pz == ZONE_MIN_HARD || pz == ZONE_MAX_HARD) begin
            hold = (pz == ZONE_MIN_HARD) ? tlim : -tlim;
            alpha = (pz == ZONE_MIN_HARD) ? ramp_frac(q, hmin, qmin) : ramp_frac(q, hmax, qmax);
            a2 = (alpha * alpha) >>> 16;
            res = tau + ((a2 * (hold - tau)) >>> 16) - ((kvel * dq) >>> 16);
        end else if (vz == ZONE_MIN_SOFT || vz == ZONE_MAX_SOFT) begin
            alpha = (vz == ZONE_MIN_SOFT) ? ramp_frac(dq, vsmin, vhmin)
                                          : ramp_frac(dq, vsmax, vhmax);
            res = ((65536 - alpha) * tau) >>> 16;
        end else if (vz == ZONE_MIN_HARD || vz == ZONE_MAX_HARD) begin
            alpha = (vz == ZONE_MIN_HARD) ? ramp_frac(dq, vhmin, -vmax) : ramp_frac(dq, vhmax, vmax);
            a2 = (alpha * alpha) >>> 16;
            a4 = (a2 * a2) >>> 16;
            res = (a4 * tlim * 655) >>> 32;
            if (vz == ZONE_MAX_HARD) res = -res;
        end
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        r.torque_out = res[31:0];
        r.position_zone = pz;
        r.velocity_zone = vz;
        r.limited = (pz != ZONE_SAFE) || (vz != ZONE_SAFE);
        return r;
    endfunction

    // receiver stalls: stall_cnt paces random redraws of the mode, mode 0 never stalls
    int stall_mode = 0;
    int stall_cnt = 0;
    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 64 == 63) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= $urandom_range(0, 1);
            2: m_ready <= (stall_cnt % 4 == 0);
            default: m_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (shaped_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", m_data);
            end else begin
                want = shaped_q.pop_front();
                if (m_data.torque_out !== want.torque_out ||
                    m_data.position_zone !== want.position_zone ||
                    m_data.velocity_zone !== want.velocity_zone ||
                    m_data.limited !== want.limited) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 want.torque_out, want.position_zone, want.velocity_zone,
                                 want.limited, m_data.torque_out, m_data.position_zone,
                                 m_data.velocity_zone, m_data.limited);
                end
            end
        end
    end

    // push the predicted word at acceptance; directed rows may carry a typed result
    task automatic send_word(in_t w, bit typed, out_t typed_res);
        out_t p;
        int   gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        p = shape_torque(w);
        if (typed && p !== typed_res) begin
            errors++;
            if (errors <= 10) $display("typed row differs from prediction");
        end
        shaped_q.push_back(typed ? typed_res : p);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (shaped_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_limit(logic [2:0] idx, logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_ANGLE_MIN: qmin = longint'(signed'(v[18:0]));
            CFG_ANGLE_MAX: qmax = v[18:0];
            CFG_ANGLE_TOL: atol = v[16:0];
            CFG_VEL_LIM:   vmax = v[18:0];
            CFG_VEL_TOL:   vtol = v[16:0];
            CFG_TORQUE:    tlim = v[23:0];
            CFG_DAMPING:   kvel = v[24:0];
            default: ;
        endcase
    endtask

    task automatic load_limits(logic [31:0] a, b, c, d, e, f, g);
        write_limit(CFG_ANGLE_MIN, a);
        write_limit(CFG_ANGLE_MAX, b);
        write_limit(CFG_ANGLE_TOL, c);
        write_limit(CFG_VEL_LIM, d);
        write_limit(CFG_VEL_TOL, e);
        write_limit(CFG_TORQUE, f);
        write_limit(CFG_DAMPING, g);
    endtask

    function automatic logic [31:0] near(longint centre, longint span);
        longint off;
        off = longint'($urandom_range(0, 2 * span + 8)) - span - 4;
        return 32'(centre + off);
    endfunction

    function automatic logic [31:0] pick_angle();
        longint pmin, pmax;
        pmin = (qmin * 64225) >>> 16;
        pmax = (qmax * 64225) >>> 16;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return near(qmin, 2 * atol);
            2: return near(pmin + 6 * atol, 2 * atol);
            3: return near(pmin + 9 * atol, 2 * atol);
            4: return near(pmax - 9 * atol, 2 * atol);
            5: return near(pmax - 6 * atol, 2 * atol);
            6: return near(qmax, 2 * atol);
            default: return near(0, 4096);
        endcase
    endfunction

    function automatic logic [31:0] pick_speed();
        longint vl;
        vl = (vmax * 64225) >>> 16;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return near(-vmax, 3 * vtol);
            2: return near(-vl + 8 * vtol, 2 * vtol);
            3: return near(-vl + 10 * vtol, 2 * vtol);
            4: return near(vl - 10 * vtol, 2 * vtol);
            5: return near(vl - 8 * vtol, 2 * vtol);
            6: return near(vmax, 3 * vtol);
            default: return near(0, 65536);
        endcase
    endfunction

    task automatic random_words(int count);
        in_t w;
        repeat (count) begin
            w.torque_in = ($urandom_range(0, 2) == 0) ? $urandom : near(0, 1 << 22);
            w.joint_angle = pick_angle();
            w.joint_velocity = pick_speed();
            send_word(w, 1'b0, '0);
        end
    endtask

    typedef struct {
        in_t  w;
        bit   typed;
        out_t res;
    } row_t;

    localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    row_t rows[17] = '{
        '{'{32'sh0001_2345, 0, 0}, 1, '{32'sh0001_2345, ZONE_SAFE, ZONE_SAFE, 1'b0}},
        '{'{0, SMIN, 0}, 1, '{32'sd5701632, ZONE_MIN_HARD, ZONE_SAFE, 1'b1}},
        '{'{0, SMAX, 0}, 1, '{-32'sd5701632, ZONE_MAX_HARD, ZONE_SAFE, 1'b1}},
        '{'{SMAX, 0, 0}, 1, '{SMAX, ZONE_SAFE, ZONE_SAFE, 1'b0}},
        '{'{SMIN, 0, 0}, 1, '{SMIN, ZONE_SAFE, ZONE_SAFE, 1'b0}},
        '{'{0, 0, SMAX}, 1, '{-32'sd56985, ZONE_SAFE, ZONE_MAX_HARD, 1'b1}},
        '{'{0, 0, SMIN}, 1, '{32'sd56985, ZONE_SAFE, ZONE_MIN_HARD, 1'b1}},
        '{'{SMAX, SMIN, SMIN}, 0, '0},
        '{'{SMIN, SMAX, SMAX}, 0, '0},
        '{'{32'sd70000, -32'sd180185, 0}, 0, '0},
        '{'{32'sd70000, -32'sd181000, 32'sd300000}, 0, '0},
        '{'{-32'sd70000, 32'sd181000, -32'sd300000}, 0, '0},
        '{'{32'sd1000, -32'sd185000, -32'sd5000}, 0, '0},
        '{'{32'sd1000, 32'sd184000, 32'sd5000}, 0, '0},
        '{'{32'sd90000, 0, 32'sd133139}, 0, '0},
        '{'{32'sd90000, 0, 32'sd134000}, 0, '0},
        '{'{-32'sd90000, 0, -32'sd134000}, 0, '0}
    };

    initial begin
        qmin = -189878;
        qmax = 189878;
        atol = 655;
        vmax = 142541;
        vtol = 655;
        tlim = 5701632;
        kvel = 6553600;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);
        random_words(200);
        drain();

        // wide limits: zones overlap
        load_limits(-32'sd262144, 262144, 65536, 262144, 65536, 8388608, 16777216);
        random_words(170);
        drain();

        // all zero: every boundary coincides
        load_limits(0, 0, 0, 0, 0, 0, 0);
        random_words(120);
        drain();

        // beyond range: all ones within each width; unknown index dropped
        load_limits('1, '1, '1, '1, '1, '1, '1);
        write_limit(3'd7, 32'h0000_1234);
        random_words(170);
        drain();

        repeat (2) begin
            load_limits(-32'(longint'($urandom_range(0, 262144))), $urandom_range(0, 262144),
                        $urandom_range(0, 4000), $urandom_range(0, 262144),
                        $urandom_range(0, 4000), $urandom_range(0, 8388608),
                        $urandom_range(0, 16777216));
            random_words(200);
            drain();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
